// ----- rtl/core/priority_region_map_insert_assert.svh -----
// assertion macros for the region map
`ifndef PRIORITY_REGION_MAP_INSERT_ASSERT_SVH
`define PRIORITY_REGION_MAP_INSERT_ASSERT_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define PRMI_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("region map check failed");

// next-cycle implication, clocked on clk_i, off during reset
`define PRMI_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("region map check failed");

`endif

// ----- rtl/core/prmi_pkg.sv -----
// shared constants, types and command/status bundles of the region map
package prmi_pkg;

  localparam int unsigned MAP_DEPTH = 128;
  localparam int unsigned IDX_W     = $clog2(MAP_DEPTH);
  localparam int unsigned CNT_W     = $clog2(MAP_DEPTH + 1);
  localparam int unsigned ADDR_W    = 64;
  localparam int unsigned TYPE_W    = 4;
  localparam int unsigned INDEX_W   = 7;
  localparam int unsigned COUNT_W   = 8;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0] head;
    logic [ADDR_W-1:0] tail;
    logic [TYPE_W-1:0] ty;
  } region_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic fetch;
    logic load;
    logic step;
    logic flush;
    logic res_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic work;
    logic more;
    logic adv;
    logic fail;
    logic fin;
    logic out_busy;
  } sts_t;

endpackage

// ----- rtl/core/prmi_ctrl.sv -----
// sequencing state machine of the region map
module prmi_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  prmi_pkg::sts_t  sts_i,
  output prmi_pkg::cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FETCH = 3'd1;
  localparam logic [2:0] S_LOAD  = 3'd2;
  localparam logic [2:0] S_STEP  = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;
  localparam logic [2:0] S_RES   = 3'd5;

  logic [2:0] state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = sts_i.work ? S_FETCH : S_RES;
        end
      end
      S_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d     = sts_i.more ? S_LOAD : S_STEP;
      end
      S_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = S_STEP;
      end
      S_STEP: begin
        cmd_o.step = 1'b1;
        priority if (sts_i.fail) begin
          state_d = S_RES;
        end else if (sts_i.fin) begin
          state_d = S_FLUSH;
        end else if (sts_i.adv) begin
          state_d = S_FETCH;
        end
      end
      S_FLUSH: begin
        cmd_o.flush = 1'b1;
        state_d     = S_RES;
      end
      S_RES: begin
        if (!sts_i.out_busy) begin
          cmd_o.res_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/core/prmi_dp.sv -----
// region table banks, merge walk registers and result word
`include "priority_region_map_insert_assert.svh"

module prmi_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  prmi_pkg::cmd_t                      cmd_i,
  output prmi_pkg::sts_t                      sts_o,
  input  logic                                command_i,
  input  logic [prmi_pkg::ADDR_W-1:0]         region_base_i,
  input  logic [prmi_pkg::ADDR_W-1:0]         region_size_i,
  input  logic [prmi_pkg::TYPE_W-1:0]         region_type_i,
  input  logic [prmi_pkg::INDEX_W-1:0]        entry_index_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [prmi_pkg::ADDR_W-1:0]         entry_head_o,
  output logic [prmi_pkg::ADDR_W-1:0]         entry_tail_o,
  output logic [prmi_pkg::TYPE_W-1:0]         entry_type_o,
  output logic                                entry_valid_o,
  output logic [prmi_pkg::COUNT_W-1:0]        region_count_o,
  output logic                                overflow_error_o
);

  // two banks: live table and the one being rebuilt
  prmi_pkg::region_t mem_q [2*prmi_pkg::MAP_DEPTH];
  prmi_pkg::region_t rdata_q;

  logic                          live_q, live_d;
  logic [prmi_pkg::CNT_W-1:0]    used_q, used_d;
  logic                          ovf_q, ovf_d;
  logic                          op_rd_q, hit_q;
  logic [prmi_pkg::ADDR_W-1:0]   h_q, h_d, t_q;
  logic [prmi_pkg::TYPE_W-1:0]   ty_q;
  prmi_pkg::region_t             cur_q, cur_d, prev_q, prev_d, spl_q, spl_d;
  logic                          cur_v_q, cur_v_d, prev_v_q, prev_v_d, spl_v_q, spl_v_d;
  logic                          drain_q, drain_d;
  logic [prmi_pkg::CNT_W-1:0]    rd_ptr_q, rd_ptr_d, wr_ptr_q, wr_ptr_d, cnt_q, cnt_d;

  logic                          push;
  prmi_pkg::region_t             push_val;
  logic                          adv, fin, fail;
  logic                          wp, wn, spl_merge;
  logic                          rd_en, wr_en;
  logic [prmi_pkg::IDX_W:0]      rd_addr, wr_addr;
  logic [prmi_pkg::ADDR_W:0]     sum_w;
  logic [prmi_pkg::ADDR_W-1:0]   tail_in, gap_t;
  logic                          more;

  // saturating tail of the new range
  assign sum_w   = {1'b0, region_base_i} + {1'b0, region_size_i}
                 - {{prmi_pkg::ADDR_W{1'b0}}, 1'b1};
  assign tail_in = sum_w[prmi_pkg::ADDR_W] ? '1 : sum_w[prmi_pkg::ADDR_W-1:0];

  assign more = (rd_ptr_q < used_q);

  // end of the gap piece ahead of the current entry
  assign gap_t = (!cur_v_q || (cur_q.head > t_q)) ? t_q : (cur_q.head - 1'b1);
  assign wp = prev_v_q && (prev_q.ty == ty_q) && ((prev_q.tail + 1'b1) == h_q);
  assign wn = cur_v_q && (cur_q.ty == ty_q) && ((gap_t + 1'b1) == cur_q.head);
  assign spl_merge = cur_v_q && (cur_q.ty == spl_q.ty) && ((spl_q.tail + 1'b1) == cur_q.head);

  // one walk step over the current entry
  always_comb begin
    h_d      = h_q;
    cur_d    = cur_q;
    prev_d   = prev_q;
    spl_d    = spl_q;
    spl_v_d  = spl_v_q;
    drain_d  = drain_q;
    cnt_d    = cnt_q;
    push     = 1'b0;
    push_val = cur_q;
    adv      = 1'b0;
    fin      = 1'b0;
    fail     = 1'b0;
    if (cmd_i.step) begin
      priority if (drain_q && spl_v_q) begin
        // tail piece of a split region, merged into the next one if it touches and has the same type
        spl_v_d = 1'b0;
        if (spl_merge) begin
          cur_d.head = spl_q.head;
        end else if (cnt_q >= prmi_pkg::CNT_W'(prmi_pkg::MAP_DEPTH)) begin
          fail = 1'b1;
        end else begin
          push     = 1'b1;
          push_val = spl_q;
          cnt_d    = cnt_q + 1'b1;
        end
      end else if (drain_q) begin
        // copy out the rest of the table
        if (cur_v_q) begin
          push = 1'b1;
          adv  = 1'b1;
        end else begin
          fin = 1'b1;
        end
      end else if (spl_v_q) begin
        // new range goes between the two halves
        drain_d = 1'b1;
        if (cnt_q >= prmi_pkg::CNT_W'(prmi_pkg::MAP_DEPTH)) begin
          fail = 1'b1;
        end else begin
          push     = 1'b1;
          push_val = '{head: h_q, tail: t_q, ty: ty_q};
          cnt_d    = cnt_q + 1'b1;
        end
      end else if (!cur_v_q || (cur_q.head > t_q) || (h_q < cur_q.head)) begin
        // gap piece before the current entry
        if (!cur_v_q || (cur_q.head > t_q)) begin
          drain_d = 1'b1;
        end else begin
          h_d = cur_q.head;
        end
        priority if (wp && wn) begin
          prev_d.tail = cur_q.tail;
          cnt_d       = cnt_q - 1'b1;
          adv         = 1'b1;
          if (cur_q.tail >= t_q) begin
            drain_d = 1'b1;
          end else begin
            h_d = cur_q.tail + 1'b1;
          end
        end else if (wp) begin
          prev_d.tail = gap_t;
        end else if (wn) begin
          cur_d.head = h_q;
        end else if (cnt_q >= prmi_pkg::CNT_W'(prmi_pkg::MAP_DEPTH)) begin
          fail = 1'b1;
        end else begin
          push     = 1'b1;
          push_val = '{head: h_q, tail: gap_t, ty: ty_q};
          cnt_d    = cnt_q + 1'b1;
        end
      end else if (cur_q.tail < h_q) begin
        push = 1'b1;
        adv  = 1'b1;
      end else if (cur_q.ty >= ty_q) begin
        // equal or higher type keeps its part
        if (cur_q.tail >= t_q) begin
          drain_d = 1'b1;
        end else begin
          h_d  = cur_q.tail + 1'b1;
          push = 1'b1;
          adv  = 1'b1;
        end
      end else if ((cur_q.head >= h_q) && (cur_q.tail <= t_q)) begin
        cnt_d = cnt_q - 1'b1;
        adv   = 1'b1;
      end else if (cur_q.head >= h_q) begin
        cur_d.head = t_q + 1'b1;
      end else if (cur_q.tail <= t_q) begin
        cur_d.tail = h_q - 1'b1;
      end else begin
        // split a losing region around the new range
        push          = 1'b1;
        push_val      = cur_q;
        push_val.tail = h_q - 1'b1;
        spl_d         = '{head: t_q + 1'b1, tail: cur_q.tail, ty: cur_q.ty};
        spl_v_d       = 1'b1;
        adv           = 1'b1;
      end
    end
    // a pushed piece becomes the pending write
    if (push) begin
      prev_d = push_val;
    end
  end

  // status
  always_comb begin
    sts_o          = '0;
    sts_o.work     = (command_i == prmi_pkg::CMD_ADD) && !ovf_q && (region_size_i != '0);
    sts_o.more     = more;
    sts_o.adv      = adv;
    sts_o.fail     = fail;
    sts_o.fin      = fin;
    sts_o.out_busy = out_valid_o && out_stall_i;
  end

  // pointers, pending entries and commit
  always_comb begin
    live_d   = live_q;
    used_d   = used_q;
    ovf_d    = ovf_q | fail;
    cur_v_d  = cur_v_q;
    prev_v_d = prev_v_q;
    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    if (push) begin
      prev_v_d = 1'b1;
    end
    if (push && prev_v_q) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (adv) begin
      cur_v_d = 1'b0;
    end
    if (cmd_i.fetch && more) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (cmd_i.load) begin
      cur_v_d = 1'b1;
    end
    if (cmd_i.flush) begin
      live_d = ~live_q;
      used_d = cnt_q;
    end
  end

  // memory ports
  assign rd_en   = cmd_i.accept || (cmd_i.fetch && more);
  assign rd_addr = cmd_i.accept ? {live_q, entry_index_i[prmi_pkg::IDX_W-1:0]}
                                : {live_q, rd_ptr_q[prmi_pkg::IDX_W-1:0]};
  assign wr_en   = prev_v_q && ((cmd_i.step && push) || cmd_i.flush);
  assign wr_addr = {~live_q, wr_ptr_q[prmi_pkg::IDX_W-1:0]};

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
    if (wr_en) begin
      mem_q[wr_addr] <= prev_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q   <= 1'b0;
      used_q   <= '0;
      ovf_q    <= 1'b0;
      cur_v_q  <= 1'b0;
      prev_v_q <= 1'b0;
      spl_v_q  <= 1'b0;
      drain_q  <= 1'b0;
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      cnt_q    <= '0;
    end else if (cmd_i.accept) begin
      cur_v_q  <= 1'b0;
      prev_v_q <= 1'b0;
      spl_v_q  <= 1'b0;
      drain_q  <= 1'b0;
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      cnt_q    <= used_q;
    end else begin
      live_q   <= live_d;
      used_q   <= used_d;
      ovf_q    <= ovf_d;
      cur_v_q  <= cur_v_d;
      prev_v_q <= prev_v_d;
      spl_v_q  <= spl_v_d;
      drain_q  <= drain_d;
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // walk payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_rd_q <= (command_i == prmi_pkg::CMD_READ);
      hit_q   <= (prmi_pkg::CNT_W'(entry_index_i) < used_q);
      h_q     <= region_base_i;
      t_q     <= tail_in;
      ty_q    <= region_type_i;
    end else begin
      h_q <= h_d;
    end
    cur_q  <= cmd_i.load ? rdata_q : cur_d;
    prev_q <= prev_d;
    spl_q  <= spl_d;
  end

  // result word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.res_load) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      if (op_rd_q && hit_q) begin
        entry_head_o  <= rdata_q.head;
        entry_tail_o  <= rdata_q.tail;
        entry_type_o  <= rdata_q.ty;
        entry_valid_o <= 1'b1;
      end else begin
        entry_head_o  <= '0;
        entry_tail_o  <= '0;
        entry_type_o  <= '0;
        entry_valid_o <= 1'b0;
      end
      region_count_o   <= prmi_pkg::COUNT_W'(used_q);
      overflow_error_o <= ovf_q;
    end
  end

  // checks
  `PRMI_ASSERT_NOW(a_wr_in_range, wr_en, wr_ptr_q < prmi_pkg::CNT_W'(prmi_pkg::MAP_DEPTH))
  `PRMI_ASSERT_NOW(a_commit_count, cmd_i.flush, cnt_q == (wr_ptr_q + prmi_pkg::CNT_W'(prev_v_q)))
  `PRMI_ASSERT_NXT(a_ovf_sticky, ovf_q, ovf_q)

endmodule

// ----- rtl/core/priority_region_map_insert.sv -----
// top level of the priority region map
//
// Input channel (in_valid_i / in_stall_o) takes one word: an add of a
// region (command 0) or a read of one table entry (command 1). The
// output channel (out_valid_o / out_stall_i) returns exactly one word
// per input word, in order.
// A read fetches its entry from the table on accept and then goes to the
// result state, which loads the output register. An add rebuilds the table
// into the spare bank: fetch, load and step for each old entry, plus a step
// for each extra piece (gap, trim or split).
// A zero-size add, or any add after overflow, finishes like a read.
// One word is in work at a time; the walk over the table memory sets the
// rate.
// A finished word waits in the output register while out_stall_i is high;
// the next input word is taken meanwhile and held before its result until
// the register frees up.
// Reset empties the table and clears the overflow flag at once; no
// clearing pass is needed.
module priority_region_map_insert (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           command_i,
  input  logic [prmi_pkg::ADDR_W-1:0]    region_base_i,
  input  logic [prmi_pkg::ADDR_W-1:0]    region_size_i,
  input  logic [prmi_pkg::TYPE_W-1:0]    region_type_i,
  input  logic [prmi_pkg::INDEX_W-1:0]   entry_index_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [prmi_pkg::ADDR_W-1:0]    entry_head_o,
  output logic [prmi_pkg::ADDR_W-1:0]    entry_tail_o,
  output logic [prmi_pkg::TYPE_W-1:0]    entry_type_o,
  output logic                           entry_valid_o,
  output logic [prmi_pkg::COUNT_W-1:0]   region_count_o,
  output logic                           overflow_error_o
);

  prmi_pkg::cmd_t cmd;
  prmi_pkg::sts_t sts;

  // sequencer
  prmi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // table and walk datapath
  prmi_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .command_i        (command_i),
    .region_base_i    (region_base_i),
    .region_size_i    (region_size_i),
    .region_type_i    (region_type_i),
    .entry_index_i    (entry_index_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .entry_head_o     (entry_head_o),
    .entry_tail_o     (entry_tail_o),
    .entry_type_o     (entry_type_o),
    .entry_valid_o    (entry_valid_o),
    .region_count_o   (region_count_o),
    .overflow_error_o (overflow_error_o)
  );

endmodule

// ----- test/priority_region_map_insert_check.sv -----
// checker for the region map: watches both channels, predicts and compares
module priority_region_map_insert_check (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic                           command_i,
  input  logic [prmi_pkg::ADDR_W-1:0]    region_base_i,
  input  logic [prmi_pkg::ADDR_W-1:0]    region_size_i,
  input  logic [prmi_pkg::TYPE_W-1:0]    region_type_i,
  input  logic [prmi_pkg::INDEX_W-1:0]   entry_index_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic [prmi_pkg::ADDR_W-1:0]    entry_head_i,
  input  logic [prmi_pkg::ADDR_W-1:0]    entry_tail_i,
  input  logic [prmi_pkg::TYPE_W-1:0]    entry_type_i,
  input  logic                           entry_valid_i,
  input  logic [prmi_pkg::COUNT_W-1:0]   region_count_i,
  input  logic                           overflow_error_i,
  input  logic                           check_end_i,
  output int                             fail_count_o,
  output int                             pending_o,
  output int                             table_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [prmi_pkg::ADDR_W-1:0] addr_t;
  typedef logic [prmi_pkg::TYPE_W-1:0] rty_t;

  typedef struct packed {
    addr_t                         head;
    addr_t                         tail;
    rty_t                          ty;
    logic                          hit;
    logic [prmi_pkg::COUNT_W-1:0]  count;
    logic                          ovf;
  } entry_word_t;

  // committed map and scratch map used while an add is laid over it
  addr_t map_head [prmi_pkg::MAP_DEPTH];
  addr_t map_tail [prmi_pkg::MAP_DEPTH];
  rty_t  map_ty   [prmi_pkg::MAP_DEPTH];
  int    map_count;
  logic  map_ovf;

  addr_t scr_head [prmi_pkg::MAP_DEPTH];
  addr_t scr_tail [prmi_pkg::MAP_DEPTH];
  rty_t  scr_ty   [prmi_pkg::MAP_DEPTH];
  int    scr_count;
  logic  scr_fail;

  entry_word_t expected_words[$];
  int          mismatches;
  int          lost_words;
  int          pending_n;

  assign fail_count_o  = mismatches + lost_words;
  assign pending_o     = pending_n;
  assign table_count_o = map_count;

  function automatic void scr_drop(int i);
    if (i >= scr_count) return;
    for (int j = i; j + 1 < scr_count; j++) begin
      scr_head[j] = scr_head[j+1];
      scr_tail[j] = scr_tail[j+1];
      scr_ty[j]   = scr_ty[j+1];
    end
    scr_count--;
  endfunction

  function automatic void scr_open(int i, addr_t h, addr_t t, rty_t ty);
    if (scr_count >= prmi_pkg::MAP_DEPTH || i > scr_count) begin
      scr_fail = 1'b1;
      return;
    end
    for (int j = scr_count; j > i; j--) begin
      scr_head[j] = scr_head[j-1];
      scr_tail[j] = scr_tail[j-1];
      scr_ty[j]   = scr_ty[j-1];
    end
    scr_head[i] = h;
    scr_tail[i] = t;
    scr_ty[i]   = ty;
    scr_count++;
  endfunction

  // put a piece into the gap before i, merging with touching same-type neighbours
  function automatic int scr_fit(int i, addr_t h, addr_t t, rty_t ty);
    logic pj, nj;
    pj = i > 0 && i <= scr_count && scr_ty[i-1] == ty && scr_tail[i-1] + 64'd1 == h;
    nj = i < scr_count && scr_ty[i] == ty && t + 64'd1 == scr_head[i];
    if (pj) begin
      if (nj) begin
        scr_tail[i-1] = scr_tail[i];
        scr_drop(i);
      end else begin
        scr_tail[i-1] = t;
      end
      return i - 1;
    end
    if (nj) begin
      scr_head[i] = h;
      return i;
    end
    scr_open(i, h, t, ty);
    return i;
  endfunction

  function automatic void overlay(addr_t head, addr_t tail, rty_t ty);
    int    idx;
    addr_t rh, rt;
    rty_t  rty;
    idx = scr_count;
    while (idx > 0 && scr_tail[idx-1] >= head) idx--;
    while (head <= tail && !scr_fail) begin
      if (idx >= scr_count || scr_head[idx] > tail) begin
        void'(scr_fit(idx, head, tail, ty));
        break;
      end
      if (scr_tail[idx] < head) begin
        idx++;
        continue;
      end
      rh = scr_head[idx];
      if (head < rh) begin
        idx  = scr_fit(idx, head, rh - 64'd1, ty);
        head = rh;
        continue;
      end
      rt  = scr_tail[idx];
      rty = scr_ty[idx];
      if (rty >= ty) begin
        if (rt >= tail) break;
        head = rt + 64'd1;
        idx++;
        continue;
      end
      if (!(rh < head) && !(tail < rt)) begin
        scr_drop(idx);
        continue;
      end
      if (!(rh < head)) begin
        scr_head[idx] = tail + 64'd1;
        continue;
      end
      scr_tail[idx] = head - 64'd1;
      if (!(tail < rt)) continue;
      idx = scr_fit(idx + 1, tail + 64'd1, rt, rty);
    end
  endfunction

  function automatic entry_word_t map_apply(logic cmd, addr_t base, addr_t size, rty_t ty,
                                            logic [prmi_pkg::INDEX_W-1:0] k);
    entry_word_t w;
    addr_t       tail;
    w = '0;
    if (cmd == prmi_pkg::CMD_READ) begin
      if (int'(k) < map_count) begin
        w.head = map_head[k];
        w.tail = map_tail[k];
        w.ty   = map_ty[k];
        w.hit  = 1'b1;
      end
    end else if (!map_ovf && size != '0) begin
      tail = base + (size - 64'd1);
      if (base > tail) tail = '1;
      scr_count = map_count;
      for (int i = 0; i < map_count; i++) begin
        scr_head[i] = map_head[i];
        scr_tail[i] = map_tail[i];
        scr_ty[i]   = map_ty[i];
      end
      scr_fail = 1'b0;
      overlay(base, tail, ty);
      if (scr_fail) begin
        map_ovf = 1'b1;
      end else begin
        for (int i = 0; i < scr_count; i++) begin
          map_head[i] = scr_head[i];
          map_tail[i] = scr_tail[i];
          map_ty[i]   = scr_ty[i];
        end
        map_count = scr_count;
      end
    end
    w.count = map_count[prmi_pkg::COUNT_W-1:0];
    w.ovf   = map_ovf;
    return w;
  endfunction

  // predict on input words, compare on output words
  always @(posedge clk_i or negedge rst_ni) begin
    entry_word_t e, a;
    if (!rst_ni) begin
      map_count  = 0;
      map_ovf    = 1'b0;
      mismatches = 0;
      expected_words.delete();
      pending_n  = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        a = '{entry_head_i, entry_tail_i, entry_type_i, entry_valid_i,
              region_count_i, overflow_error_i};
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word %p", $time, a);
          mismatches++;
        end else begin
          e = expected_words.pop_front();
          if (a !== e) begin
            $display("%0t: mismatch expected %p actual %p", $time, e, a);
            mismatches++;
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_words.push_back(map_apply(command_i, region_base_i, region_size_i,
                                           region_type_i, entry_index_i));
      pending_n = expected_words.size();
    end
  end

  // words still owed at the end of the run
  initial lost_words = 0;
  always @(posedge check_end_i) begin
    if (expected_words.size() != 0) begin
      $display("%0t: %0d words never arrived", $time, expected_words.size());
      lost_words++;
    end
  end
endmodule

// ----- test/priority_region_map_insert_test.sv -----
// top of the region map testbench: stimulus, clock, reset and verdict
module priority_region_map_insert_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic                                clk_i = 1'b0;
  logic                                rst_ni = 1'b0;
  logic                                in_valid = 1'b0;
  logic                                in_stall;
  logic                                command = prmi_pkg::CMD_ADD;
  logic [prmi_pkg::ADDR_W-1:0]         region_base = '0;
  logic [prmi_pkg::ADDR_W-1:0]         region_size = '0;
  logic [prmi_pkg::TYPE_W-1:0]         region_type = '0;
  logic [prmi_pkg::INDEX_W-1:0]        entry_index = '0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic [prmi_pkg::ADDR_W-1:0]         entry_head, entry_tail;
  logic [prmi_pkg::TYPE_W-1:0]         entry_type;
  logic                                entry_valid, overflow_error;
  logic [prmi_pkg::COUNT_W-1:0]        region_count;
  logic                                check_end = 1'b0;
  int                                  fail_count, pending, table_count;
  int                                  cycles = 0;
  logic                                long_hold = 1'b0;
  logic                                calm = 1'b0;

  always #1 clk_i = ~clk_i;

  priority_region_map_insert dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .command_i(command), .region_base_i(region_base), .region_size_i(region_size),
    .region_type_i(region_type), .entry_index_i(entry_index),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .entry_head_o(entry_head), .entry_tail_o(entry_tail), .entry_type_o(entry_type),
    .entry_valid_o(entry_valid), .region_count_o(region_count),
    .overflow_error_o(overflow_error)
  );

  priority_region_map_insert_check checker_i (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_i(in_stall), .command_i(command),
    .region_base_i(region_base), .region_size_i(region_size),
    .region_type_i(region_type), .entry_index_i(entry_index),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .entry_head_i(entry_head), .entry_tail_i(entry_tail), .entry_type_i(entry_type),
    .entry_valid_i(entry_valid), .region_count_i(region_count),
    .overflow_error_i(overflow_error), .check_end_i(check_end),
    .fail_count_o(fail_count), .pending_o(pending), .table_count_o(table_count)
  );

  // receiver: random stalls, one long hold-off, calm stretch without stalls
  always @(posedge clk_i) begin
    if (long_hold) out_stall <= 1'b1;
    else if (calm) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < 7);
  end

  initial begin
    repeat (60) @(posedge clk_i);
    long_hold = 1'b1;
    repeat (3000) @(posedge clk_i);
    long_hold = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // offer one word and hold it until taken; valid stays up for the next word
  task automatic send_word(logic cmd, logic [prmi_pkg::ADDR_W-1:0] b,
                           logic [prmi_pkg::ADDR_W-1:0] s,
                           logic [prmi_pkg::TYPE_W-1:0] t,
                           logic [prmi_pkg::INDEX_W-1:0] k);
    while (!calm && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid    <= 1'b1;
    command     <= cmd;
    region_base <= b;
    region_size <= s;
    region_type <= t;
    entry_index <= k;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  function automatic logic [prmi_pkg::ADDR_W-1:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  // clustered addresses so regions overlap, touch and merge often
  task automatic send_add(logic [prmi_pkg::ADDR_W-1:0] zone);
    logic [prmi_pkg::ADDR_W-1:0] b, s;
    b = zone + 64'($urandom_range(4095));
    case ($urandom_range(9))
      0:       s = rnd64();
      1:       s = '0;
      default: s = 64'($urandom_range(1, 600));
    endcase
    send_word(prmi_pkg::CMD_ADD, b, s, 4'($urandom), 7'($urandom));
  endtask

  task automatic read_all();
    for (int i = 0; i <= table_count && i < prmi_pkg::MAP_DEPTH; i++)
      send_word(prmi_pkg::CMD_READ, rnd64(), rnd64(), 4'($urandom), 7'(i));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    logic [prmi_pkg::ADDR_W-1:0] zone;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: extremes, overlap rules, merges, wrap, empty reads
    send_word(prmi_pkg::CMD_READ, '0, '0, '0, '0);
    send_word(prmi_pkg::CMD_READ, '1, '1, '1, '1);
    send_word(prmi_pkg::CMD_ADD, 64'h1000, '0, 4'd3, '0);
    send_word(prmi_pkg::CMD_ADD, 64'h1000, 64'h100, 4'd3, '0);
    send_word(prmi_pkg::CMD_ADD, 64'h1100, 64'h100, 4'd3, '0);
    send_word(prmi_pkg::CMD_ADD, 64'h1080, 64'h20, 4'd9, '0);
    send_word(prmi_pkg::CMD_ADD, 64'h1000, 64'h300, 4'd1, '0);
    send_word(prmi_pkg::CMD_ADD, 64'h0f00, 64'h400, 4'd15, '0);
    send_word(prmi_pkg::CMD_ADD, 64'hffff_ffff_ffff_ff00, '1, 4'd2, '0);
    send_word(prmi_pkg::CMD_ADD, '0, 64'd1, '0, '0);
    send_word(prmi_pkg::CMD_ADD, '1, 64'd1, 4'd15, '0);
    send_word(prmi_pkg::CMD_ADD, 64'h5000, 64'h10, 4'd4, '0);
    send_word(prmi_pkg::CMD_ADD, 64'h5020, 64'h10, 4'd4, '0);
    send_word(prmi_pkg::CMD_ADD, 64'h5010, 64'h10, 4'd4, '0);
    read_all();
    send_word(prmi_pkg::CMD_READ, '0, '0, '0, 7'd127);
    drain();
    // receiver hold-off period then random fill
    for (int n = 0; n < 180; n++) begin
      zone = 64'($urandom_range(3)) << ($urandom_range(1) ? 62 : 13);
      if ($urandom_range(3) == 0)
        send_word(prmi_pkg::CMD_READ, rnd64(), rnd64(), 4'($urandom),
                  7'($urandom_range(table_count + 2)));
      else send_add(zone);
    end
    drain();
    read_all();
    // calm stretch without idling
    calm = 1'b1;
    for (int n = 0; n < 100; n++) send_add(64'h20000);
    calm = 1'b0;
    // push many disjoint regions until capacity is exceeded
    for (int n = 0; n < 140; n++)
      send_word(prmi_pkg::CMD_ADD, 64'h1_0000_0000 + 64'(n) * 16, 64'd4, 4'(n), '0);
    read_all();
    for (int n = 0; n < 10; n++) send_add('0);
    drain();
    repeat (20) @(posedge clk_i);
    check_end <= 1'b1;
    @(posedge clk_i);
    @(posedge clk_i);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
